FILE: sv/nat_port_pool_allocator_macros.svh
// Assertion macros for the port pool allocator.
`ifndef NAT_PORT_POOL_ALLOCATOR_MACROS_SVH
`define NAT_PORT_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NPPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("nppa check failed");
// next-cycle implication
`define NPPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("nppa check failed");
`else
`define NPPA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define NPPA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/nppa_pkg.sv
package nppa_pkg;

	localparam int POOL_SIZE = 1024;
	localparam int BASE_W    = 16;
	localparam int SO_W      = 10;
	localparam int CNT_OUT_W = 11;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int NWORDS    = (POOL_SIZE + WORD_W - 1) / WORD_W;
	localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IDX_W     = WA_W + BIT_W;
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int CFG_A_W   = 1;

	localparam logic [BASE_W-1:0] BASE_RESET = 16'd49152;

	// register indexes
	localparam logic [CFG_A_W-1:0] REG_BASE_PORT    = 1'b0;
	localparam logic [CFG_A_W-1:0] REG_START_OFFSET = 1'b1;

	// actions
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// status codes
	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_IGNORED   = 2'd3;

	typedef struct packed {
		logic              re;
		logic [WA_W-1:0]   raddr;
		logic              we;
		logic [WA_W-1:0]   waddr;
		logic [WORD_W-1:0] wdata;
	} nppa_mem_req_t;

	typedef struct packed {
		logic [BASE_W-1:0] granted_port;
		logic [1:0]        status;
		logic [CNT_W-1:0]  ports_in_use;
	} nppa_res_t;

	// bits of a word that fall past the end of the pool read as used
	function automatic logic [WORD_W-1:0] tail_mask(input logic [WA_W-1:0] w);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (int'(w) * WORD_W + i >= POOL_SIZE)
				m[i] = 1'b1;
		end
		return m;
	endfunction

	// lowest clear bit; found flag in the top bit
	function automatic logic [BIT_W:0] find_zero(input logic [WORD_W-1:0] v);
		logic [BIT_W:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!v[i])
				r = {1'b1, BIT_W'(i)};
		end
		return r;
	endfunction

endpackage

FILE: sv/nppa_map_ram.sv
module nppa_map_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nppa_pkg::nppa_mem_req_t     req,
	output logic [nppa_pkg::WORD_W-1:0] rd_data
);
	import nppa_pkg::*;

	logic [WORD_W-1:0] mem [NWORDS];
	logic [NWORDS-1:0] vld_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvld_q;

	// rows never written since reset read as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we)
				vld_q[req.waddr] <= 1'b1;
			if (req.re)
				rvld_q <= vld_q[req.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem[req.raddr];
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

FILE: sv/nppa_ctrl.sv
`include "nat_port_pool_allocator_macros.svh"

module nppa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [nppa_pkg::BASE_W-1:0]   release_port,
	input  logic [nppa_pkg::BASE_W-1:0]   base_port,
	input  logic                          so_we,
	input  logic [nppa_pkg::SO_W-1:0]     so_val,
	output nppa_pkg::nppa_mem_req_t       mem_req,
	input  logic [nppa_pkg::WORD_W-1:0]   rd_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output nppa_pkg::nppa_res_t           res
);
	import nppa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_REL  = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] search_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WA_W-1:0]  word_q, word_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic             first_q, first_d;
	nppa_res_t        res_q, res_d;

	logic              acc;
	logic              full;
	logic [BASE_W-1:0] off;
	logic              in_pool;
	logic [IDX_W-1:0]  off_idx;
	logic [WORD_W-1:0] masked;
	logic [BIT_W:0]    ffz;
	logic [IDX_W-1:0]  hit_idx;
	logic [WA_W-1:0]   word_nxt;
	logic              grant, free_it;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign full     = (cnt_q == CNT_W'(POOL_SIZE));
	assign off      = release_port - base_port;
	assign in_pool  = ({1'b0, off} < (BASE_W+1)'(POOL_SIZE));
	assign off_idx  = IDX_W'(off);

	// bits below the start bit in the first visited word count as used
	assign masked   = rd_data | tail_mask(word_q)
		| (first_q ? ~({WORD_W{1'b1}} << bit_q) : '0);
	assign ffz      = find_zero(masked);
	assign hit_idx  = {word_q, ffz[BIT_W-1:0]};
	assign word_nxt = (word_q == WA_W'(NWORDS - 1)) ? '0 : word_q + 1'b1;

	assign grant    = (state_q == S_SCAN) && ffz[BIT_W];
	assign free_it  = (state_q == S_REL) && rd_data[bit_q];

	always_comb begin
		state_d = state_q;
		word_d  = word_q;
		bit_d   = bit_q;
		first_d = first_q;
		res_d   = res_q;
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					res_d.granted_port = '0;
					res_d.ports_in_use = cnt_q;
					if (action == ACT_ALLOC) begin
						if (full) begin
							res_d.status = ST_FULL;
							state_d      = S_RESP;
						end else begin
							word_d        = search_q[IDX_W-1:BIT_W];
							bit_d         = search_q[BIT_W-1:0];
							first_d       = 1'b1;
							mem_req.re    = 1'b1;
							mem_req.raddr = search_q[IDX_W-1:BIT_W];
							state_d       = S_SCAN;
						end
					end else begin
						if (in_pool) begin
							word_d        = off_idx[IDX_W-1:BIT_W];
							bit_d         = off_idx[BIT_W-1:0];
							mem_req.re    = 1'b1;
							mem_req.raddr = off_idx[IDX_W-1:BIT_W];
							state_d       = S_REL;
						end else begin
							res_d.status = ST_IGNORED;
							state_d      = S_RESP;
						end
					end
				end
			end
			S_SCAN: begin
				if (ffz[BIT_W]) begin
					mem_req.we         = 1'b1;
					mem_req.waddr      = word_q;
					mem_req.wdata      = rd_data | (WORD_W'(1) << ffz[BIT_W-1:0]);
					res_d.granted_port = base_port + BASE_W'(hit_idx);
					res_d.status       = ST_ALLOCATED;
					res_d.ports_in_use = cnt_q + 1'b1;
					state_d            = S_RESP;
				end else begin
					// wraps back to the start word with the full mask
					word_d        = word_nxt;
					first_d       = 1'b0;
					mem_req.re    = 1'b1;
					mem_req.raddr = word_nxt;
				end
			end
			S_REL: begin
				if (free_it) begin
					mem_req.we         = 1'b1;
					mem_req.waddr      = word_q;
					mem_req.wdata      = rd_data & ~(WORD_W'(1) << bit_q);
					res_d.status       = ST_RELEASED;
					res_d.ports_in_use = cnt_q - 1'b1;
				end else begin
					res_d.status = ST_IGNORED;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			search_q <= '0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (so_we)
				search_q <= IDX_W'(so_val % POOL_SIZE);
			else if (grant)
				search_q <= (hit_idx == IDX_W'(POOL_SIZE - 1)) ? '0 : hit_idx + 1'b1;
			if (grant)
				cnt_q <= cnt_q + 1'b1;
			else if (free_it)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		word_q  <= word_d;
		bit_q   <= bit_d;
		first_q <= first_d;
		res_q   <= res_d;
	end

	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	`NPPA_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(POOL_SIZE))
	`NPPA_ASSERT_IMP(a_scan_not_full, clk, arst_n, state_q == S_SCAN, !full)
	`NPPA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, res_valid, !in_ready)
	`NPPA_ASSERT_IMP(a_rw_words_differ, clk, arst_n, mem_req.we && mem_req.re,
		mem_req.waddr != mem_req.raddr)
	`NPPA_ASSERT_NXT(a_grant_resp, clk, arst_n, grant, res_valid)

endmodule

FILE: sv/nat_port_pool_allocator.sv
// Port pool allocator, next-fit over a word-wide bitmap memory (32 ports per word).
// Pool full and out-of-pool release are answered from the idle state; a release reads one
// bitmap word; an allocate inspects k bitmap words (1..NWORDS+1), wrapping past the last word.
// One item at a time: next beat is taken once the result has left for the output register;
// the bitmap memory has one read and one write port, and the scan reads one word at a time.
// Async reset: bitmap reads all free at once (row valid bits), count 0, search index 0.
module nat_port_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // release_port
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // granted_port[15:0], ports_in_use[26:16], zero fill
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data
);
	import nppa_pkg::*;

	logic [BASE_W-1:0]  base_q;
	nppa_mem_req_t      mem_req;
	logic [WORD_W-1:0]  rd_data;
	logic               res_valid, res_ready;
	nppa_res_t          res;
	logic               so_we;

	logic               out_valid_q;
	logic [BASE_W-1:0]  out_port_q;
	logic [1:0]         out_status_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;

	assign so_we = cfg_we && (cfg_addr == REG_START_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_q <= BASE_RESET;
		else if (cfg_we && cfg_addr == REG_BASE_PORT)
			base_q <= cfg_data;
	end

	nppa_map_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	nppa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.action       (s_tuser),
		.release_port (s_tdata),
		.base_port    (base_q),
		.so_we        (so_we),
		.so_val       (cfg_data[SO_W-1:0]),
		.mem_req      (mem_req),
		.rd_data      (rd_data),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// output register decouples the result from the next search
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_port_q   <= res.granted_port;
			out_status_q <= res.status;
			out_cnt_q    <= CNT_OUT_W'(res.ports_in_use);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_cnt_q, out_port_q};
	assign m_tuser  = out_status_q;

endmodule
